[rtl/core/spc_pkg.sv]
`timescale 1ns / 1ps
package spc_pkg;

    localparam int FRAC_BITS = 16;
    localparam int CW        = 32;
    localparam int DIFF_W    = CW + 1;
    localparam int PROD_W    = CW + DIFF_W;
    localparam int DIST_W    = PROD_W + 2;
    localparam int REM_W     = DIST_W + 1;
    localparam int LPROD_W   = DIFF_W + FRAC_BITS + 1;
    localparam int IDX_W     = 3;

    localparam logic [IDX_W-1:0] REG_POINT_X  = 3'd0;
    localparam logic [IDX_W-1:0] REG_POINT_Y  = 3'd1;
    localparam logic [IDX_W-1:0] REG_POINT_Z  = 3'd2;
    localparam logic [IDX_W-1:0] REG_NORMAL_X = 3'd3;
    localparam logic [IDX_W-1:0] REG_NORMAL_Y = 3'd4;
    localparam logic [IDX_W-1:0] REG_NORMAL_Z = 3'd5;

    typedef enum logic [1:0] {
        ST_REJECT = 2'd0,
        ST_PASS   = 2'd1,
        ST_SECOND = 2'd2,
        ST_FIRST  = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0][2:0][CW-1:0] pos;
        logic [1:0][2:0][CW-1:0] tex;
    } t_seg;

    typedef struct packed {
        logic [2:0][CW-1:0] point;
        logic [2:0][CW-1:0] normal;
    } t_plane;

    typedef struct packed {
        t_seg                 seg;
        t_status              status;
        logic                 mv;
        logic [REM_W-1:0]     rem;
        logic [REM_W-1:0]     den;
        logic [FRAC_BITS-1:0] q;
    } t_div;

    typedef struct packed {
        t_seg    seg;
        t_status status;
    } t_res;

endpackage

[rtl/core/spc_cfg.sv]
`timescale 1ns / 1ps
module spc_cfg (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [spc_pkg::IDX_W-1:0] i_cfg_index,
    input  logic [spc_pkg::CW-1:0]    i_cfg_data,
    output spc_pkg::t_plane           o_plane
);

    spc_pkg::t_plane r_plane;
    spc_pkg::t_plane n_plane;

    assign o_cfg_ready = 1'b1;
    assign o_plane     = r_plane;

    always_comb begin
        n_plane = r_plane;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                spc_pkg::REG_POINT_X:  n_plane.point[0]  = i_cfg_data;
                spc_pkg::REG_POINT_Y:  n_plane.point[1]  = i_cfg_data;
                spc_pkg::REG_POINT_Z:  n_plane.point[2]  = i_cfg_data;
                spc_pkg::REG_NORMAL_X: n_plane.normal[0] = i_cfg_data;
                spc_pkg::REG_NORMAL_Y: n_plane.normal[1] = i_cfg_data;
                spc_pkg::REG_NORMAL_Z: n_plane.normal[2] = i_cfg_data;
                default:               n_plane = r_plane;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane <= '0;
        end else begin
            r_plane <= n_plane;
        end
    end

endmodule

[rtl/core/spc_dist.sv]
`timescale 1ns / 1ps
module spc_dist (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  spc_pkg::t_seg   i_seg,
    input  spc_pkg::t_plane i_plane,
    output logic            o_valid,
    input  logic            i_ready,
    output spc_pkg::t_div   o_item
);

    logic [3:0] r_v;
    logic [3:0] rdy;

    spc_pkg::t_seg r_seg_a, r_seg_b, r_seg_c;
    logic signed [spc_pkg::DIFF_W-1:0] r_diff [2][3];
    logic signed [spc_pkg::DIFF_W-1:0] n_diff [2][3];
    logic signed [spc_pkg::PROD_W-1:0] r_prod [2][3];
    logic signed [spc_pkg::PROD_W-1:0] n_prod [2][3];
    logic signed [spc_pkg::DIST_W-1:0] r_dist [2];
    logic signed [spc_pkg::DIST_W-1:0] n_dist [2];
    spc_pkg::t_div r_item, n_item;

    logic                            out0, out1;
    logic signed [spc_pkg::DIST_W-1:0] din_s;
    logic [spc_pkg::REM_W-1:0]        din, dout;

    always_comb begin
        rdy[3] = !r_v[3] || i_ready;
        for (int k = 2; k >= 0; k--) begin
            rdy[k] = !r_v[k] || rdy[k+1];
        end
    end

    assign o_ready = rdy[0];
    assign o_valid = r_v[3];
    assign o_item  = r_item;

    always_comb begin
        for (int e = 0; e < 2; e++) begin
            for (int i = 0; i < 3; i++) begin
                n_diff[e][i] = $signed({i_seg.pos[e][i][spc_pkg::CW-1], i_seg.pos[e][i]})
                             - $signed({i_plane.point[i][spc_pkg::CW-1], i_plane.point[i]});
                n_prod[e][i] = $signed(i_plane.normal[i]) * r_diff[e][i];
            end
            n_dist[e] = r_prod[e][0] + r_prod[e][1] + r_prod[e][2];
        end
    end

    // outside when strictly positive
    always_comb begin
        out0  = !r_dist[0][spc_pkg::DIST_W-1] && (r_dist[0] != '0);
        out1  = !r_dist[1][spc_pkg::DIST_W-1] && (r_dist[1] != '0);
        din_s = out1 ? -r_dist[0] : -r_dist[1];
        din   = {1'b0, din_s};
        dout  = out1 ? {1'b0, r_dist[1]} : {1'b0, r_dist[0]};
        n_item.seg = r_seg_c;
        n_item.mv  = out1;
        n_item.rem = din;
        n_item.den = din + dout;
        n_item.q   = '0;
        if (out0 && out1) begin
            n_item.status = spc_pkg::ST_REJECT;
        end else if (!out0 && !out1) begin
            n_item.status = spc_pkg::ST_PASS;
        end else if (out1) begin
            n_item.status = spc_pkg::ST_SECOND;
        end else begin
            n_item.status = spc_pkg::ST_FIRST;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (rdy[0]) r_v[0] <= i_valid;
            if (rdy[1]) r_v[1] <= r_v[0];
            if (rdy[2]) r_v[2] <= r_v[1];
            if (rdy[3]) r_v[3] <= r_v[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0] && i_valid) begin
            r_seg_a <= i_seg;
            r_diff  <= n_diff;
        end
        if (rdy[1] && r_v[0]) begin
            r_seg_b <= r_seg_a;
            r_prod  <= n_prod;
        end
        if (rdy[2] && r_v[1]) begin
            r_seg_c <= r_seg_b;
            r_dist  <= n_dist;
        end
        if (rdy[3] && r_v[2]) begin
            r_item <= n_item;
        end
    end

endmodule

[rtl/core/spc_div.sv]
`timescale 1ns / 1ps
module spc_div (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  spc_pkg::t_div i_item,
    output logic          o_valid,
    input  logic          i_ready,
    output spc_pkg::t_div o_item
);

    localparam int N = spc_pkg::FRAC_BITS;

    logic          r_v [N];
    logic          rdy [N+1];
    spc_pkg::t_div r_st [N];
    spc_pkg::t_div n_st [N];
    logic          in_v [N];

    assign rdy[N]  = i_ready;
    assign o_ready = rdy[0];
    assign o_valid = r_v[N-1];
    assign o_item  = r_st[N-1];

    for (genvar k = 0; k < N; k++) begin : g_step
        spc_pkg::t_div            src;
        logic [spc_pkg::REM_W-1:0] shl;
        logic                      ge;

        assign rdy[k]  = !r_v[k] || rdy[k+1];
        assign src     = (k == 0) ? i_item : r_st[(k == 0) ? 0 : k-1];
        assign in_v[k] = (k == 0) ? i_valid : r_v[(k == 0) ? 0 : k-1];

        // one restoring quotient bit per stage
        always_comb begin
            shl      = {src.rem[spc_pkg::REM_W-2:0], 1'b0};
            ge       = (shl >= src.den);
            n_st[k]  = src;
            n_st[k].rem = ge ? (shl - src.den) : shl;
            n_st[k].q   = {src.q[N-2:0], ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (rdy[k]) begin
                r_v[k] <= in_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (rdy[k] && in_v[k]) begin
                r_st[k] <= n_st[k];
            end
        end
    end

endmodule

[rtl/core/spc_lerp.sv]
`timescale 1ns / 1ps
module spc_lerp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  spc_pkg::t_div i_item,
    output logic          o_valid,
    input  logic          i_ready,
    output spc_pkg::t_res o_res
);

    logic [1:0] r_v;
    logic [1:0] rdy;

    spc_pkg::t_seg    r_seg;
    spc_pkg::t_status r_status;
    logic             r_mv;
    logic signed [spc_pkg::LPROD_W-1:0] r_pp [3], r_tp [3];
    logic signed [spc_pkg::LPROD_W-1:0] n_pp [3], n_tp [3];
    logic signed [spc_pkg::DIFF_W-1:0]  dp, dt;
    logic signed [spc_pkg::FRAC_BITS:0] f;
    spc_pkg::t_res r_res, n_res;

    assign rdy[1]  = !r_v[1] || i_ready;
    assign rdy[0]  = !r_v[0] || rdy[1];
    assign o_ready = rdy[0];
    assign o_valid = r_v[1];
    assign o_res   = r_res;

    always_comb begin
        f  = $signed({1'b0, i_item.q});
        dp = '0;
        dt = '0;
        for (int i = 0; i < 3; i++) begin
            dp = $signed({i_item.seg.pos[i_item.mv][i][spc_pkg::CW-1],
                          i_item.seg.pos[i_item.mv][i]})
               - $signed({i_item.seg.pos[!i_item.mv][i][spc_pkg::CW-1],
                          i_item.seg.pos[!i_item.mv][i]});
            dt = $signed({i_item.seg.tex[i_item.mv][i][spc_pkg::CW-1],
                          i_item.seg.tex[i_item.mv][i]})
               - $signed({i_item.seg.tex[!i_item.mv][i][spc_pkg::CW-1],
                          i_item.seg.tex[!i_item.mv][i]});
            n_pp[i] = dp * f;
            n_tp[i] = dt * f;
        end
    end

    // arithmetic shift floors the step; the sum always fits the field
    always_comb begin
        n_res.seg    = r_seg;
        n_res.status = r_status;
        if (r_status == spc_pkg::ST_REJECT) begin
            n_res.seg = '0;
        end else if (r_status != spc_pkg::ST_PASS) begin
            for (int i = 0; i < 3; i++) begin
                n_res.seg.pos[r_mv][i] = r_seg.pos[!r_mv][i]
                    + r_pp[i][spc_pkg::FRAC_BITS +: spc_pkg::CW];
                n_res.seg.tex[r_mv][i] = r_seg.tex[!r_mv][i]
                    + r_tp[i][spc_pkg::FRAC_BITS +: spc_pkg::CW];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (rdy[0]) r_v[0] <= i_valid;
            if (rdy[1]) r_v[1] <= r_v[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0] && i_valid) begin
            r_seg    <= i_item.seg;
            r_status <= i_item.status;
            r_mv     <= i_item.mv;
            r_pp     <= n_pp;
            r_tp     <= n_tp;
        end
        if (rdy[1] && r_v[0]) begin
            r_res <= n_res;
        end
    end

endmodule

[rtl/core/segment_plane_clipper.sv]
`timescale 1ns / 1ps
// Stages: 4 distance stages, one divider stage per fraction bit,
// 2 interpolation stages and an output register. Each segment leaves as two
// endpoint beats on the output; rejected segments take one beat. Pipeline
// accepts a beat per cycle while o_stall is low.
// Reset: synchronous active low; clears the plane registers and all valid bits.
module segment_plane_clipper (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [spc_pkg::IDX_W-1:0] i_cfg_index,
    input  logic [31:0]               i_cfg_data,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic signed [31:0]        i_start_x,
    input  logic signed [31:0]        i_start_y,
    input  logic signed [31:0]        i_start_z,
    input  logic signed [31:0]        i_end_x,
    input  logic signed [31:0]        i_end_y,
    input  logic signed [31:0]        i_end_z,
    input  logic signed [31:0]        i_start_tex_u,
    input  logic signed [31:0]        i_start_tex_v,
    input  logic signed [31:0]        i_start_tex_w,
    input  logic signed [31:0]        i_end_tex_u,
    input  logic signed [31:0]        i_end_tex_v,
    input  logic signed [31:0]        i_end_tex_w,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [1:0]                o_status,
    output logic                      o_endpoint,
    output logic signed [31:0]        o_pos_x,
    output logic signed [31:0]        o_pos_y,
    output logic signed [31:0]        o_pos_z,
    output logic signed [31:0]        o_tex_u,
    output logic signed [31:0]        o_tex_v,
    output logic signed [31:0]        o_tex_w,
    output logic                      o_last
);

    spc_pkg::t_plane plane;
    spc_pkg::t_seg   seg_in;
    spc_pkg::t_div   dist_item, div_item;
    spc_pkg::t_res   lerp_res;
    logic            dist_ready, dist_valid, div_ready, div_valid;
    logic            lerp_ready, lerp_valid, out_ready;

    spc_pkg::t_res r_res;
    logic          r_v;
    logic          r_ep;
    logic          take, done, reject;

    assign seg_in.pos[0][0] = i_start_x;
    assign seg_in.pos[0][1] = i_start_y;
    assign seg_in.pos[0][2] = i_start_z;
    assign seg_in.pos[1][0] = i_end_x;
    assign seg_in.pos[1][1] = i_end_y;
    assign seg_in.pos[1][2] = i_end_z;
    assign seg_in.tex[0][0] = i_start_tex_u;
    assign seg_in.tex[0][1] = i_start_tex_v;
    assign seg_in.tex[0][2] = i_start_tex_w;
    assign seg_in.tex[1][0] = i_end_tex_u;
    assign seg_in.tex[1][1] = i_end_tex_v;
    assign seg_in.tex[1][2] = i_end_tex_w;

    spc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_plane     (plane)
    );

    spc_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (dist_ready),
        .i_seg   (seg_in),
        .i_plane (plane),
        .o_valid (dist_valid),
        .i_ready (div_ready),
        .o_item  (dist_item)
    );

    spc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (dist_valid),
        .o_ready (div_ready),
        .i_item  (dist_item),
        .o_valid (div_valid),
        .i_ready (lerp_ready),
        .o_item  (div_item)
    );

    spc_lerp u_lerp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (div_valid),
        .o_ready (lerp_ready),
        .i_item  (div_item),
        .o_valid (lerp_valid),
        .i_ready (out_ready),
        .o_res   (lerp_res)
    );

    assign o_stall   = !dist_ready;
    assign reject    = (r_res.status == spc_pkg::ST_REJECT);
    assign take      = r_v && !i_stall;
    assign done      = take && (r_ep || reject);
    assign out_ready = !r_v || done;

    // emit the first endpoint, then the second; a rejected segment ends at once
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= 1'b0;
            r_ep <= 1'b0;
        end else if (out_ready) begin
            r_v  <= lerp_valid;
            r_ep <= 1'b0;
        end else if (take) begin
            r_ep <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready && lerp_valid) begin
            r_res <= lerp_res;
        end
    end

    assign o_valid    = r_v;
    assign o_status   = r_res.status;
    assign o_endpoint = r_ep;
    assign o_last     = r_ep || reject;
    assign o_pos_x    = r_res.seg.pos[r_ep][0];
    assign o_pos_y    = r_res.seg.pos[r_ep][1];
    assign o_pos_z    = r_res.seg.pos[r_ep][2];
    assign o_tex_u    = r_res.seg.tex[r_ep][0];
    assign o_tex_v    = r_res.seg.tex[r_ep][1];
    assign o_tex_w    = r_res.seg.tex[r_ep][2];

endmodule
